// File: design/dds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDS waveform generator package
// Shared widths, wave shape codes and the half-period sine table.
// ----------------------------------------------------------------------------
package dds_pkg;

	localparam int PHASE_W     = 16;
	localparam int SAMPLE_W    = 8;
	localparam int SHAPE_W     = 3;
	localparam int TABLE_DEPTH = 128;
	localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

	// Wave shape register codes; 0 and 7 are unused and give a zero sample.
	localparam logic [SHAPE_W-1:0] SHAPE_HALF_SQUARE = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_SAW         = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE    = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_SINE        = 3'd4;
	localparam logic [SHAPE_W-1:0] SHAPE_RECT_SINE   = 3'd5;
	localparam logic [SHAPE_W-1:0] SHAPE_FULL_SQUARE = 3'd6;
	localparam logic [SHAPE_W-1:0] SHAPE_RESET       = SHAPE_HALF_SQUARE;

	// One half period, rising from mid-scale to full scale and back.
	localparam logic [SAMPLE_W-1:0] SINE_ROM [0:TABLE_DEPTH-1] = '{
		8'd127, 8'd130, 8'd133, 8'd136, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
		8'd198, 8'd201, 8'd204, 8'd206, 8'd208, 8'd211, 8'd213, 8'd216,
		8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
		8'd234, 8'd235, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd244,
		8'd245, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252,
		8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd253,
		8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
		8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
		8'd233, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
		8'd217, 8'd214, 8'd212, 8'd210, 8'd207, 8'd205, 8'd202, 8'd200,
		8'd197, 8'd194, 8'd192, 8'd189, 8'd186, 8'd183, 8'd180, 8'd178,
		8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
		8'd151, 8'd147, 8'd144, 8'd141, 8'd138, 8'd135, 8'd132, 8'd129
	};

endpackage
`default_nettype wire

// File: design/dds_phase_acc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDS phase accumulator
// Adds the phase step of each accepted transaction to the wrapping phase and
// registers the top byte of the new phase as stage one.
// ----------------------------------------------------------------------------
module dds_phase_acc (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  accept,
	input  wire logic                                  load_s1,
	input  wire logic [dds_pkg::PHASE_W-1:0]           phase_step,
	output logic                                       valid_s1,
	output logic [dds_pkg::SAMPLE_W-1:0]               top_s1
);

	logic [dds_pkg::PHASE_W-1:0] phase_acc_q;
	logic [dds_pkg::PHASE_W-1:0] phase_next;

	// The sum wraps modulo the accumulator width.
	assign phase_next = phase_acc_q + phase_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				phase_acc_q <= phase_next;
			end
			if (load_s1) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= phase_next[dds_pkg::PHASE_W-1 -: dds_pkg::SAMPLE_W];
		end
	end

endmodule
`default_nettype wire

// File: design/dds_shaper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDS wave shaper
// Maps the top phase byte to a sample for the selected wave shape.
// ----------------------------------------------------------------------------
module dds_shaper (
	input  wire logic [dds_pkg::SHAPE_W-1:0]  wave_shape,
	input  wire logic [dds_pkg::SAMPLE_W-1:0] top_phase,
	output logic [dds_pkg::SAMPLE_W-1:0]      sample
);

	logic                                 half;
	logic [dds_pkg::TABLE_IDX_W-1:0]      fold;
	logic [dds_pkg::SAMPLE_W-1:0]         rom_data;

	// The second half of the cycle mirrors the index back onto the first half.
	assign half     = top_phase[dds_pkg::SAMPLE_W-1];
	assign fold     = top_phase[dds_pkg::TABLE_IDX_W-1:0] ^ {dds_pkg::TABLE_IDX_W{half}};
	assign rom_data = dds_pkg::SINE_ROM[fold];

	always_comb begin
		case (wave_shape)
			dds_pkg::SHAPE_HALF_SQUARE: sample = {half, {(dds_pkg::SAMPLE_W-1){1'b0}}};
			dds_pkg::SHAPE_SAW:         sample = top_phase;
			dds_pkg::SHAPE_TRIANGLE:    sample = {fold, 1'b0};
			dds_pkg::SHAPE_SINE:        sample = rom_data ^ {dds_pkg::SAMPLE_W{half}};
			dds_pkg::SHAPE_RECT_SINE:   sample = rom_data;
			dds_pkg::SHAPE_FULL_SQUARE: sample = {dds_pkg::SAMPLE_W{half}};
			default:                    sample = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: design/dds_waveform_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDS waveform generator core
// Phase accumulator with a selectable wave shape and a registered sample.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the phase channel (phase_valid, phase_stall,
// phase_step) is one sample tick: the step is added to a 16-bit wrapping
// phase, and one sample transaction follows on the sample channel
// (sample_valid, sample_stall, sample_out), in order.
// The wave shape register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce
// this. It resets to the half-level square. On acceptance the new phase top
// byte is registered in stage one; the shaped sample is then registered in
// the output register once that register can load, and sample_valid rises
// with it. Throughput is one sample per cycle while the receiver does not
// stall, as the accumulator add and the table lookup are combinational.
// When the receiver stalls, the output register holds its sample and one
// more tick can wait in the accumulator stage; phase_stall rises only when
// both are full. Reset clears the phase to zero and empties both stages.
// ----------------------------------------------------------------------------
module dds_waveform_generator_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [dds_pkg::SHAPE_W-1:0]           cfg_wdata,
	input  wire logic                                  phase_valid,
	output logic                                       phase_stall,
	input  wire logic [dds_pkg::PHASE_W-1:0]           phase_step,
	output logic                                       sample_valid,
	input  wire logic                                  sample_stall,
	output logic [dds_pkg::SAMPLE_W-1:0]               sample_out
);

	logic [dds_pkg::SHAPE_W-1:0]  wave_shape_q;
	logic                         valid_s1;
	logic [dds_pkg::SAMPLE_W-1:0] top_s1;
	logic [dds_pkg::SAMPLE_W-1:0] shaped;
	logic                         load_s2;
	logic                         load_s1;
	logic                         accept;

	assign load_s2     = !sample_valid || !sample_stall;
	assign load_s1     = !valid_s1 || load_s2;
	assign phase_stall = !load_s1;
	assign accept      = phase_valid && load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q <= dds_pkg::SHAPE_RESET;
		end else if (cfg_we) begin
			wave_shape_q <= cfg_wdata;
		end
	end

	dds_phase_acc u_phase_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.load_s1    (load_s1),
		.phase_step (phase_step),
		.valid_s1   (valid_s1),
		.top_s1     (top_s1)
	);

	dds_shaper u_shaper (
		.wave_shape (wave_shape_q),
		.top_phase  (top_s1),
		.sample     (shaped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (load_s2) begin
			sample_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			sample_out <= shaped;
		end
	end

endmodule
`default_nettype wire

// File: design/dds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDS waveform generator port checker
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module dds_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         phase_stall,
	input  wire logic                         sample_valid,
	input  wire logic                         sample_stall,
	input  wire logic [dds_pkg::SAMPLE_W-1:0] sample_out
);

	// A stalled sample stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid)
		else $error("sample transaction dropped while stalled");

	// A stalled sample keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> $stable(sample_out))
		else $error("sample changed while stalled");

	// With the output register empty, the block must take a new tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		!sample_valid |-> !phase_stall)
		else $error("input stalled with an empty output register");

	// A sample leaving frees room, so the input cannot be stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |-> !phase_stall)
		else $error("input stalled while the output drains");

endmodule

bind dds_waveform_generator_core dds_checker u_dds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.phase_stall  (phase_stall),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample_out   (sample_out)
);
`default_nettype wire
